// ===== rtl/core/whitespace_token_classifier_assert.svh =====
// Assertion macros for the whitespace token classifier.
// Expect clk_i and rst_ni in the scope of every use.
`ifndef WHITESPACE_TOKEN_CLASSIFIER_ASSERT_SVH
`define WHITESPACE_TOKEN_CLASSIFIER_ASSERT_SVH

// Flag a condition that must never hold at a clock edge.
`define WTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Flag a precondition whose consequence fails in the same cycle.
`define WTC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/wtc_pkg.sv =====
// Shared types, codes and helpers for the whitespace token classifier.
// No dependencies.
package wtc_pkg;

  localparam int unsigned TOK_LEN_W  = 6;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam logic [7:0]  ZERO_CHAR  = 8'd48;

  localparam logic [1:0] EV_START  = 2'd0;
  localparam logic [1:0] EV_NUMBER = 2'd1;
  localparam logic [1:0] EV_STRING = 2'd2;
  localparam logic [1:0] EV_END    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [63:0] number_value;
    logic [7:0]  text_byte;
    logic        token_end;
    logic        truncated;
    logic        run_last;
  } out_item_t;

  // One request's worth of work for the replay side.
  typedef struct packed {
    logic                 has_start;
    logic                 has_num;
    logic                 has_str;
    logic                 has_end;
    logic                 bank;
    logic                 cut;
    logic [TOK_LEN_W-1:0] len;
    logic [63:0]          value;
  } cmd_t;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [TOK_LEN_W-1:0] idx;
    logic [7:0]           data;
  } buf_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ZERO_CHAR) && (c <= ZERO_CHAR + 8'd9);
  endfunction

endpackage

// ===== rtl/core/whitespace_token_classifier.sv =====
// Whitespace token classifier, top level. Depends on wtc_pkg and the assert macros.
// A request passes the work queue, the replay state and the output register in turn.
// Throughput: one request per cycle in while full is low, one result per cycle
//   out of the output register while pop is high; one result per string byte.
// Reset: asynchronous, clears all control state; no clearing pass, the token
//   memory holds nothing valid until written.
`include "whitespace_token_classifier_assert.svh"

module whitespace_token_classifier
  import wtc_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  // Front end decodes each request, accumulates the decimal value and writes
  // token bytes into one of two memory banks. A bank stays locked until the
  // replay side has played its string back, so the front can fill the other.
  cmd_t      cmd_in, cmd_out;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  buf_wr_t   buf_wr;
  bank_rel_t bank_rel;

  wtc_front #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .cmd_full_i(cmd_full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in),
    .wr_o      (buf_wr),
    .rel_i     (bank_rel)
  );

  // Hold queued work so either side can stall without blocking the other.
  wtc_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  // Replay side: advance through start, token and end results of each queued
  // request, one per cycle while the output is popped, and flag run_last on the final one.
  wtc_back #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (buf_wr),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .rel_o      (bank_rel),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

  `WTC_ASSERT_NEVER(a_cmd_overflow, cmd_push && cmd_full, "work queue written while full")
  `WTC_ASSERT_IMPL(a_end_is_last, !empty && out_item_o.event_kind == EV_END, out_item_o.run_last, "frame end result without run_last")
  `WTC_ASSERT_IMPL(a_non_string_clean, !empty && out_item_o.event_kind != EV_STRING, !out_item_o.token_end && !out_item_o.truncated && out_item_o.text_byte == 8'd0, "string fields set on a non-string result")

endmodule

// ===== rtl/core/wtc_front.sv =====
// Front end: takes input requests, tracks the open token and queues work.
// Depends on wtc_pkg.
module wtc_front
  import wtc_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_item_i,
  output logic      full_o,
  input  logic      cmd_full_i,
  output logic      cmd_push_o,
  output cmd_t      cmd_o,
  output buf_wr_t   wr_o,
  input  bank_rel_t rel_i
);

  typedef struct packed {
    logic                 open;
    logic                 all_dig;
    logic                 ovf;
    logic [63:0]          value;
    logic [TOK_LEN_W-1:0] len;
    logic                 cut;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{open: 1'b0, all_dig: 1'b1, ovf: 1'b0, value: '0,
                                 len: '0, cut: 1'b0};
  localparam logic [TOK_LEN_W-1:0] LEN_LIMIT = TOK_LEN_W'(MAX_TOKEN_BYTES);

  tok_t       tok_q, tok_d;
  logic       frame_q, frame_d;
  logic       wbank_q, wbank_d;
  logic [1:0] busy_q, busy_d;
  logic       active;
  logic       close;
  logic [67:0] prod;
  logic [3:0]  digit;

  assign full_o = cmd_full_i || busy_q[wbank_q];
  assign active = push_i && !full_o &&
                  (in_item_i.byte_present || in_item_i.frame_last);

  always_comb begin
    tok_d      = tok_q;
    frame_d    = frame_q;
    wbank_d    = wbank_q;
    busy_d     = busy_q;
    cmd_o      = '0;
    cmd_push_o = 1'b0;
    wr_o       = '0;
    close      = 1'b0;
    prod       = '0;
    digit      = '0;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (active) begin
      if (!frame_q) begin
        frame_d         = 1'b1;
        cmd_o.has_start = 1'b1;
        tok_d           = TOK_CLEAR;
      end
      if (in_item_i.byte_present) begin
        if (is_space(in_item_i.data_byte)) begin
          close = tok_d.open;
        end else begin
          if (!tok_d.open) begin
            tok_d      = TOK_CLEAR;
            tok_d.open = 1'b1;
          end
          if (is_digit(in_item_i.data_byte)) begin
            digit = 4'(in_item_i.data_byte - ZERO_CHAR);
            prod  = ({4'b0, tok_d.value} << 3) + ({4'b0, tok_d.value} << 1) + 68'(digit);
            if (tok_d.all_dig && !tok_d.ovf) begin
              if (prod[67:64] != 4'd0) begin
                tok_d.ovf = 1'b1;
              end else begin
                tok_d.value = prod[63:0];
              end
            end
          end else begin
            tok_d.all_dig = 1'b0;
          end
          if (tok_d.len < LEN_LIMIT) begin
            wr_o.en   = 1'b1;
            wr_o.bank = wbank_q;
            wr_o.idx  = tok_d.len;
            wr_o.data = in_item_i.data_byte;
            tok_d.len = tok_d.len + 1'b1;
          end else begin
            tok_d.cut = 1'b1;
          end
        end
      end
      if (in_item_i.frame_last) begin
        if (tok_d.open) begin
          close = 1'b1;
        end
        cmd_o.has_end = 1'b1;
        frame_d       = 1'b0;
      end
      if (close) begin
        if (tok_d.all_dig && !tok_d.ovf) begin
          cmd_o.has_num = 1'b1;
          cmd_o.value   = tok_d.value;
        end else begin
          // hand the filled bank to the replay side and switch banks
          cmd_o.has_str   = 1'b1;
          cmd_o.bank      = wbank_q;
          cmd_o.len       = tok_d.len;
          cmd_o.cut       = tok_d.cut;
          wbank_d         = ~wbank_q;
          busy_d[wbank_q] = 1'b1;
        end
        tok_d = TOK_CLEAR;
      end
      cmd_push_o = cmd_o.has_start || cmd_o.has_num || cmd_o.has_str || cmd_o.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= TOK_CLEAR;
      frame_q <= 1'b0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      tok_q   <= tok_d;
      frame_q <= frame_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

// ===== rtl/core/wtc_cmd_fifo.sv =====
// Short work queue between the front end and the replay side.
// Depends on wtc_pkg.
module wtc_cmd_fifo
  import wtc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slot_q [CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/core/wtc_back.sv =====
// Replay side: token byte memory, result sequencing and output register.
// Depends on wtc_pkg.
module wtc_back
  import wtc_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  buf_wr_t   wr_i,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output bank_rel_t rel_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  localparam int unsigned ADDR_W = $clog2(2 * MAX_TOKEN_BYTES);

  function automatic logic [ADDR_W-1:0] buf_addr(input logic bank,
                                                 input logic [TOK_LEN_W-1:0] idx);
    return bank ? ADDR_W'(MAX_TOKEN_BYTES) + ADDR_W'(idx) : ADDR_W'(idx);
  endfunction

  logic [7:0]           mem_q [2 * MAX_TOKEN_BYTES];
  logic [7:0]           rdata_q;
  logic                 active_q, active_d;
  cmd_t                 cur_q, cur_d;
  logic [TOK_LEN_W-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;
  out_item_t            res;
  logic                 load_ok, emit, last, take, str_end;

  assign load_ok = !out_valid_q || pop_i;
  assign str_end = ((idx_q + 1'b1) == cur_q.len);

  always_comb begin
    cur_d       = cur_q;
    idx_d       = idx_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res         = '0;
    emit        = 1'b0;
    last        = 1'b0;
    rel_o       = '0;
    if (active_q && load_ok) begin
      emit = 1'b1;
      if (cur_q.has_start) begin
        res.event_kind  = EV_START;
        cur_d.has_start = 1'b0;
        last = !(cur_q.has_num || cur_q.has_str || cur_q.has_end);
      end else if (cur_q.has_num) begin
        res.event_kind   = EV_NUMBER;
        res.number_value = cur_q.value;
        cur_d.has_num    = 1'b0;
        last = !cur_q.has_end;
      end else if (cur_q.has_str) begin
        res.event_kind = EV_STRING;
        res.text_byte  = rdata_q;
        res.token_end  = str_end;
        res.truncated  = cur_q.cut;
        if (str_end) begin
          cur_d.has_str = 1'b0;
          rel_o.valid   = 1'b1;
          rel_o.bank    = cur_q.bank;
        end else begin
          idx_d = idx_q + 1'b1;
        end
        last = str_end && !cur_q.has_end;
      end else begin
        res.event_kind = EV_END;
        cur_d.has_end  = 1'b0;
        last = 1'b1;
      end
      res.run_last = last;
    end
    take = (!active_q || (emit && last)) && !cmd_empty_i;
    if (take) begin
      cur_d    = cmd_i;
      idx_d    = '0;
      active_d = 1'b1;
    end else if (emit && last) begin
      active_d = 1'b0;
    end
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cmd_pop_o  = take;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // Read address follows the next byte index so rdata_q matches idx_q.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[buf_addr(wr_i.bank, wr_i.idx)] <= wr_i.data;
    end
    rdata_q <= mem_q[buf_addr(cur_d.bank, idx_d)];
    out_q   <= out_d;
    cur_q   <= cur_d;
    idx_q   <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== test/token_event_checker.sv =====
// Checker for the whitespace token classifier: watches both request channels,
// predicts token events and compares them with what the block emits.
// Depends on wtc_pkg for the request and event types.
`timescale 1ns / 100ps

module token_event_checker
  import wtc_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o,
  output int unsigned events_checked_o,
  output int unsigned number_events_o,
  output int unsigned string_events_o,
  output int unsigned truncated_events_o
);

  // Predicted tokenizer state.
  logic        frame_active;
  logic        token_active;
  logic        digits_only;
  logic        value_overflow;
  logic [63:0] token_value;
  logic [7:0]  token_bytes [$];
  int unsigned token_len;
  logic        token_cut;

  out_item_t expected_events[$];

  initial begin
    mismatch_count_o   = 0;
    pending_count_o    = 0;
    events_checked_o   = 0;
    number_events_o    = 0;
    string_events_o    = 0;
    truncated_events_o = 0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic out_item_t make_event(input logic [1:0] kind, input logic [63:0] value,
                                           input logic [7:0] text, input logic tok_end,
                                           input logic cut);
    out_item_t ev;
    ev.event_kind   = kind;
    ev.number_value = value;
    ev.text_byte    = text;
    ev.token_end    = tok_end;
    ev.truncated    = cut;
    ev.run_last     = 1'b0;
    return ev;
  endfunction

  function automatic string show_event(input out_item_t ev);
    return $sformatf("kind=%0d value=%0d byte=%02h end=%b trunc=%b last=%b",
                     ev.event_kind, ev.number_value, ev.text_byte, ev.token_end,
                     ev.truncated, ev.run_last);
  endfunction

  task automatic clear_token();
    token_active   = 1'b0;
    digits_only    = 1'b1;
    value_overflow = 1'b0;
    token_value    = '0;
    token_len      = 0;
    token_cut      = 1'b0;
    token_bytes.delete();
  endtask

  // Close the open token: a clean digit run becomes one number, all else
  // replays its stored bytes.
  task automatic flush_token();
    if (!token_active) return;
    if (digits_only && !value_overflow) begin
      expected_events.push_back(make_event(EV_NUMBER, token_value, 8'd0, 1'b0, 1'b0));
    end else begin
      for (int unsigned i = 0; i < token_len; i++) begin
        expected_events.push_back(make_event(EV_STRING, 64'd0, token_bytes[i],
                                             (i + 1 == token_len), token_cut));
      end
    end
    clear_token();
  endtask

  task automatic absorb_byte(input logic [7:0] c);
    logic [63:0] digit;
    if (!token_active) begin
      clear_token();
      token_active = 1'b1;
    end
    if (c inside {[8'h30:8'h39]}) begin
      digit = {56'd0, c - ZERO_CHAR};
      if (digits_only && !value_overflow) begin
        if (token_value > ((~64'd0) - digit) / 64'd10) value_overflow = 1'b1;
        else token_value = token_value * 64'd10 + digit;
      end
    end else begin
      digits_only = 1'b0;
    end
    if (token_len < MAX_TOKEN_BYTES) begin
      token_bytes.push_back(c);
      token_len++;
    end else begin
      token_cut = 1'b1;
    end
  endtask

  task automatic predict_events(input in_item_t req);
    int unsigned first;
    first = expected_events.size();
    if (!req.byte_present && !req.frame_last) return;
    if (!frame_active) begin
      frame_active = 1'b1;
      clear_token();
      expected_events.push_back(make_event(EV_START, 64'd0, 8'd0, 1'b0, 1'b0));
    end
    if (req.byte_present) begin
      if (is_blank(req.data_byte)) flush_token();
      else absorb_byte(req.data_byte);
    end
    if (req.frame_last) begin
      flush_token();
      expected_events.push_back(make_event(EV_END, 64'd0, 8'd0, 1'b0, 1'b0));
      frame_active = 1'b0;
    end
    if (expected_events.size() > first)
      expected_events[expected_events.size() - 1].run_last = 1'b1;
  endtask

  task automatic check_event(input out_item_t got);
    out_item_t want;
    events_checked_o++;
    if (expected_events.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t: result with nothing outstanding: %s", $time, show_event(got));
      return;
    end
    want = expected_events.pop_front();
    case (want.event_kind)
      EV_NUMBER: number_events_o++;
      EV_STRING: begin
        string_events_o++;
        if (want.truncated) truncated_events_o++;
      end
      default: ;
    endcase
    if (got.event_kind !== want.event_kind || got.number_value !== want.number_value ||
        got.text_byte !== want.text_byte || got.token_end !== want.token_end ||
        got.truncated !== want.truncated || got.run_last !== want.run_last) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10) begin
        $display("%0t: mismatch, expected %s", $time, show_event(want));
        $display("%0t:           actual   %s", $time, show_event(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_active = 1'b0;
      clear_token();
      expected_events.delete();
      pending_count_o <= 0;
    end else begin
      if (push_i && !full_i) predict_events(in_item_i);
      if (pop_i && !empty_i) check_event(out_item_i);
      pending_count_o <= expected_events.size();
    end
  end

endmodule

// ===== test/tb_whitespace_token_classifier.sv =====
// Testbench top for the whitespace token classifier: drives text frames,
// random idling on both sides, and reports the verdict.
// Depends on wtc_pkg, the block itself and token_event_checker.
`timescale 1ns / 100ps

module tb_whitespace_token_classifier;
  import wtc_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned MAX_TOKEN_BYTES = 32;
  localparam int unsigned RANDOM_REQUESTS = 400;
  // Longest legal quiet spell is a sender gap plus a receiver stall, well under this.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 16;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      push     = 1'b0;
  logic      pop      = 1'b0;
  in_item_t  in_item  = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned events_checked;
  int unsigned number_events;
  int unsigned string_events;
  int unsigned truncated_events;

  // Stimulus bookkeeping.
  int unsigned text_requests = 0;
  int unsigned idle_requests = 0;
  int unsigned frames_sent   = 0;
  int unsigned pop_hold      = 0;
  bit          quiet         = 1'b0;
  logic [7:0]  frame_text[$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  whitespace_token_classifier #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  token_event_checker #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .in_item_i         (in_item),
    .empty_i           (empty),
    .pop_i             (pop),
    .out_item_i        (out_item),
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count),
    .events_checked_o  (events_checked),
    .number_events_o   (number_events),
    .string_events_o   (string_events),
    .truncated_events_o(truncated_events)
  );

  // Pick an idle gap: mostly none or short, now and then a long one.
  // Quiet phases run both sides flat out.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Stall the result side at random; pop is touched once per edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= pick_gap();
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  initial begin : watchdog
    int unsigned stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("Watchdog: no request moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_count);
    $display("status: fail");
    $finish;
  end

  // Send one request. Called right after a rising edge; leaves push high so
  // back-to-back requests never lower and raise it in the same step.
  task automatic drive_item(input logic [7:0] c, input logic present, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      // Hold push low and scribble on the payload while idle.
      push    <= 1'b0;
      in_item <= in_item_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{data_byte: c, byte_present: present, frame_last: last};
    do @(posedge clk_i); while (full);
    if (!present && !last) idle_requests++;
    else text_requests++;
    if (last) frames_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_text.push_back(s[i]);
  endtask

  task automatic add_digits(input int unsigned n, input bit lead_nonzero);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 && lead_nonzero) frame_text.push_back(8'h30 + 8'($urandom_range(1, 9)));
      else frame_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_separator();
    logic [7:0] blanks [6];
    blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    repeat ($urandom_range(1, 3)) frame_text.push_back(blanks[3'($urandom_range(0, 5))]);
  endtask

  // Non-blank bytes of any value, forced to hold at least one non-digit.
  task automatic add_word(input int unsigned n);
    logic [7:0]  c;
    int unsigned base;
    base = frame_text.size();
    for (int unsigned i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (is_blank(c));
      frame_text.push_back(c);
    end
    do c = 8'($urandom_range(0, 255)); while (is_blank(c) || (c >= 8'h30 && c <= 8'h39));
    frame_text[base + $urandom_range(0, n - 1)] = c;
  endtask

  task automatic add_number();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      add_digits($urandom_range(1, 4), 1'b0);
    else if (r < 60) add_digits($urandom_range(5, 19), 1'b1);
    else if (r < 67) add_text("18446744073709551615");
    else if (r < 73) add_text("18446744073709551616");
    else if (r < 79) add_digits($urandom_range(20, 25), 1'b1);
    else if (r < 86) begin
      // Long run of leading zeros: often past the buffer but still a number.
      repeat ($urandom_range(28, 40)) frame_text.push_back(8'h30);
      add_digits($urandom_range(1, 3), 1'b0);
    end else add_text("0");
  endtask

  task automatic add_token();
    int unsigned r;
    if ($urandom_range(0, 99) < 55) begin
      add_number();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60)      add_word($urandom_range(1, 6));
      else if (r < 75) add_word($urandom_range(7, 31));
      else if (r < 85) add_word(MAX_TOKEN_BYTES);
      else if (r < 90) add_word(MAX_TOKEN_BYTES + 1);
      else             add_word($urandom_range(MAX_TOKEN_BYTES + 2, MAX_TOKEN_BYTES + 16));
    end
  endtask

  // Send the buffered frame; close it on its last byte or on an empty request.
  task automatic send_frame();
    bit close_on_byte;
    close_on_byte = (frame_text.size() > 0) && $urandom_range(0, 1);
    foreach (frame_text[i]) begin
      if ($urandom_range(0, 99) < 4) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive_item(frame_text[i], 1'b1, close_on_byte && (i == frame_text.size() - 1));
    end
    if (!close_on_byte) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int unsigned token_count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle before any frame, empty frame, every separator, digit
    // edges, high bytes, idle inside a frame, and each way to close a frame.
    drive_item(8'h5A, 1'b0, 1'b0);
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item("0",   1'b1, 1'b0);
    drive_item(8'h20, 1'b1, 1'b0);
    drive_item("9",   1'b1, 1'b0);
    drive_item(8'h09, 1'b1, 1'b0);
    drive_item("x",   1'b1, 1'b0);
    drive_item(8'h0A, 1'b1, 1'b0);
    drive_item(8'hFF, 1'b1, 1'b0);
    drive_item(8'h80, 1'b1, 1'b0);
    drive_item(8'h0B, 1'b1, 1'b0);
    drive_item("5",   1'b1, 1'b0);
    drive_item(8'hA5, 1'b0, 1'b0);
    drive_item(8'h0C, 1'b1, 1'b0);
    drive_item(8'h2F, 1'b1, 1'b0);
    drive_item(8'h3A, 1'b1, 1'b0);
    drive_item(8'h0D, 1'b1, 1'b0);
    drive_item(8'h08, 1'b1, 1'b0);
    drive_item(8'h0E, 1'b1, 1'b0);
    drive_item(8'h21, 1'b1, 1'b0);
    drive_item("4",   1'b1, 1'b0);
    drive_item("2",   1'b1, 1'b1);
    drive_item("a",   1'b1, 1'b1);
    drive_item("7",   1'b1, 1'b0);
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item(8'h20, 1'b1, 1'b1);

    // Random frames: mostly well-formed token streams, some raw noise.
    text_requests = 0;
    while (text_requests < RANDOM_REQUESTS) begin
      quiet = ($urandom_range(0, 4) == 0);
      frame_text.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, 12)) frame_text.push_back(8'($urandom_range(0, 255)));
      end else begin
        token_count = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) add_separator();
        for (int unsigned k = 0; k < token_count; k++) begin
          add_token();
          if (k + 1 < token_count || $urandom_range(0, 2) == 0) add_separator();
        end
      end
      send_frame();
    end

    // Drain: wait for every predicted result, then idle for DRAIN_CYCLES to catch strays.
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d text requests and %0d idle requests over %0d frames.",
             text_requests, idle_requests, frames_sent);
    $display("Checked %0d results: %0d numbers, %0d string bytes (%0d truncated), %0d bad.",
             events_checked, number_events, string_events, truncated_events, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
